// ===== design/lpcp_pkg.sv =====
// ---------------------------------------------------------------------------
// lpcp_pkg: shared types and constants of the LED pixel colour pipeline
// Payload structs of both channels, the fixed-point division constants and
// the gamma 2.8 look-up table.
// ---------------------------------------------------------------------------
`default_nettype none

package lpcp_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned INDEX_W = 10;

  // Register stages of one channel scaler, from scaler input to level out
  localparam int unsigned SHADE_LAT = 5;

  // Colour encodings of an input transaction
  localparam logic KIND_RGB = 1'b0;
  localparam logic KIND_HSV = 1'b1;

  // Hue steps per region of the six-region conversion
  localparam logic [CHAN_W-1:0] HUE_STEP = 8'd43;

  // Division by 255 * 255: multiply by floor(2^32 / 65025), then correct once
  localparam logic [16:0] DIV_MAGIC  = 17'd66051;
  localparam logic [23:0] FULL_SCALE = 24'd65025;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef struct packed {
    logic               kind;
    logic [CHAN_W-1:0]  chan_a;
    logic [CHAN_W-1:0]  chan_b;
    logic [CHAN_W-1:0]  chan_c;
    logic [CHAN_W-1:0]  seg_level;
    logic [INDEX_W-1:0] led_index;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] out_index;
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  blue_out;
  } out_item_t;

  // Pixel after colour conversion, before brightness scaling
  typedef struct packed {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  seg_level;
    logic [INDEX_W-1:0] led_index;
  } rgb_item_t;

  localparam logic [CHAN_W-1:0] GAMMA_LUT [0:255] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
    8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
    8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
    8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
    8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
    8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
    8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
    8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
    8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
    8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
    8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
    8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
    8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
    8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
    8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
    8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
    8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
    8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
    8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
    8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
    8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
    8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
    8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
    8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
  };

endpackage

`default_nettype wire

// ===== design/lpcp_hsv.sv =====
// ---------------------------------------------------------------------------
// lpcp_hsv: four-stage colour conversion front end
// Converts an HSV transaction to RGB with the six-region integer scheme;
// RGB transactions pass through. Valid travels alongside the data.
// ---------------------------------------------------------------------------
`default_nettype none

module lpcp_hsv
  import lpcp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_vld,
  input  wire in_item_t  in_item,
  output logic           out_vld,
  output rgb_item_t      out_item
);

  typedef enum logic [2:0] {
    SECT_0 = 3'd0,
    SECT_1 = 3'd1,
    SECT_2 = 3'd2,
    SECT_3 = 3'd3,
    SECT_4 = 3'd4,
    SECT_5 = 3'd5
  } sector_t;

  // Stage 1: region and fraction
  logic       vld1_r, vld1_nxt;
  in_item_t   item1_r;
  sector_t    sect1_r, sect1_nxt;
  logic [7:0] frac1_r, frac1_nxt;
  logic [7:0] base1;
  logic [7:0] rem1;
  logic [10:0] frac_wide1;

  always_comb begin
    if (in_item.chan_a >= 8'(5 * HUE_STEP)) begin
      sect1_nxt = SECT_5;
    end else if (in_item.chan_a >= 8'(4 * HUE_STEP)) begin
      sect1_nxt = SECT_4;
    end else if (in_item.chan_a >= 8'(3 * HUE_STEP)) begin
      sect1_nxt = SECT_3;
    end else if (in_item.chan_a >= 8'(2 * HUE_STEP)) begin
      sect1_nxt = SECT_2;
    end else if (in_item.chan_a >= HUE_STEP) begin
      sect1_nxt = SECT_1;
    end else begin
      sect1_nxt = SECT_0;
    end
    base1      = 8'(HUE_STEP * sect1_nxt);
    rem1       = in_item.chan_a - base1;
    frac_wide1 = {3'b000, rem1} * 11'd6;
    frac1_nxt  = frac_wide1[7:0];
    vld1_nxt   = in_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld1_nxt;
    end
    item1_r <= in_item;
    sect1_r <= sect1_nxt;
    frac1_r <= frac1_nxt;
  end

  // Stage 2: first-level products
  logic        vld2_r;
  in_item_t    item2_r;
  sector_t     sect2_r;
  logic [15:0] lo2_r, sf2_r, sr2_r;
  logic [15:0] lo2_nxt, sf2_nxt, sr2_nxt;

  always_comb begin
    lo2_nxt = {8'd0, item1_r.chan_c} * {8'd0, CHAN_MAX - item1_r.chan_b};
    sf2_nxt = {8'd0, item1_r.chan_b} * {8'd0, frac1_r};
    sr2_nxt = {8'd0, item1_r.chan_b} * {8'd0, CHAN_MAX - frac1_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    item2_r <= item1_r;
    sect2_r <= sect1_r;
    lo2_r   <= lo2_nxt;
    sf2_r   <= sf2_nxt;
    sr2_r   <= sr2_nxt;
  end

  // Stage 3: falling and rising edge products
  logic        vld3_r;
  in_item_t    item3_r;
  sector_t     sect3_r;
  logic [7:0]  lo3_r;
  logic [15:0] fall3_r, rise3_r;
  logic [15:0] fall3_nxt, rise3_nxt;

  always_comb begin
    fall3_nxt = {8'd0, item2_r.chan_c} * {8'd0, CHAN_MAX - sf2_r[15:8]};
    rise3_nxt = {8'd0, item2_r.chan_c} * {8'd0, CHAN_MAX - sr2_r[15:8]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    item3_r <= item2_r;
    sect3_r <= sect2_r;
    lo3_r   <= lo2_r[15:8];
    fall3_r <= fall3_nxt;
    rise3_r <= rise3_nxt;
  end

  // Stage 4: pick channels by region, grey and RGB bypass
  logic       vld4_r;
  rgb_item_t  item4_r, item4_nxt;
  logic [7:0] fall4, rise4, v4;

  always_comb begin
    fall4 = fall3_r[15:8];
    rise4 = rise3_r[15:8];
    v4    = item3_r.chan_c;
    item4_nxt.seg_level = item3_r.seg_level;
    item4_nxt.led_index = item3_r.led_index;
    if (item3_r.kind == KIND_RGB) begin
      item4_nxt.red   = item3_r.chan_a;
      item4_nxt.green = item3_r.chan_b;
      item4_nxt.blue  = item3_r.chan_c;
    end else if (item3_r.chan_b == 8'd0) begin
      item4_nxt.red   = v4;
      item4_nxt.green = v4;
      item4_nxt.blue  = v4;
    end else begin
      case (sect3_r)
        SECT_0: begin
          item4_nxt.red = v4;    item4_nxt.green = rise4;  item4_nxt.blue = lo3_r;
        end
        SECT_1: begin
          item4_nxt.red = fall4; item4_nxt.green = v4;     item4_nxt.blue = lo3_r;
        end
        SECT_2: begin
          item4_nxt.red = lo3_r; item4_nxt.green = v4;     item4_nxt.blue = rise4;
        end
        SECT_3: begin
          item4_nxt.red = lo3_r; item4_nxt.green = fall4;  item4_nxt.blue = v4;
        end
        SECT_4: begin
          item4_nxt.red = rise4; item4_nxt.green = lo3_r;  item4_nxt.blue = v4;
        end
        default: begin
          item4_nxt.red = v4;    item4_nxt.green = lo3_r;  item4_nxt.blue = fall4;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
    item4_r <= item4_nxt;
  end

  assign out_vld  = vld4_r;
  assign out_item = item4_r;

endmodule

`default_nettype wire

// ===== design/lpcp_shade.sv =====
// ---------------------------------------------------------------------------
// lpcp_shade: five-stage brightness scaler and gamma stage for one channel
// Computes gamma(chan * seg * global / 65025) with a reciprocal multiply and
// a single correction step.
// ---------------------------------------------------------------------------
`default_nettype none

module lpcp_shade
  import lpcp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [CHAN_W-1:0] chan,
  input  wire logic [CHAN_W-1:0] seg_level,
  input  wire logic [CHAN_W-1:0] global_level,
  output logic [CHAN_W-1:0]      level_out
);

  logic [15:0] p1_r, p1_nxt;
  logic [23:0] q2_r, q2_nxt;
  logic [23:0] q3_r;
  logic [40:0] m3_r, m3_nxt;
  logic [7:0]  est;
  logic [23:0] rem4;
  logic [8:0]  sum4;
  logic [7:0]  x4_r, x4_nxt;
  logic [7:0]  g5_r;

  always_comb begin
    p1_nxt = {8'd0, chan} * {8'd0, seg_level};
    q2_nxt = {8'd0, p1_r} * {16'd0, global_level};
    m3_nxt = {17'd0, q2_r} * {24'd0, DIV_MAGIC};
    est    = m3_r[39:32];
    // Estimate is the quotient or one below it
    rem4   = q3_r - ({16'd0, est} * FULL_SCALE);
    sum4   = {1'b0, est} + {8'd0, (rem4 >= FULL_SCALE)};
    x4_nxt = sum4[8] ? CHAN_MAX : sum4[7:0];
  end

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    q2_r <= q2_nxt;
    q3_r <= q2_r;
    m3_r <= m3_nxt;
    x4_r <= x4_nxt;
    g5_r <= GAMMA_LUT[x4_r];
  end

  assign level_out = g5_r;

endmodule

`default_nettype wire

// ===== design/led_pixel_color_pipeline.sv =====
// ---------------------------------------------------------------------------
// led_pixel_color_pipeline: LED pixel colour conversion and shading pipeline
// HSV or RGB pixel in, brightness-scaled and gamma-corrected RGB out.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive in_item and pulse start; a transaction is taken at every
//   rising edge with start high and busy low. busy is never raised, so one
//   pixel may enter on every clock.
//   Output: out_item is valid for exactly one cycle while out_strobe is
//   high. The receiver cannot hold results off, so nothing ever stalls.
//   Pipeline: a transaction taken with start high passes nine registers
//   (four in the colour converter, five in the per-channel scaler) on its
//   way to out_item. Throughput is one pixel per clock, set by the
//   fully pipelined multipliers of the scaler.
//   Configuration: cfg_data is written to the global brightness register at
//   an edge with cfg_valid and cfg_ready high; cfg_ready is always high.
//   Write it only while no pixel is in flight.
//   Reset (rst_n low, synchronous): empty the pipeline and set the global
//   brightness to full scale (255).
// ---------------------------------------------------------------------------
`default_nettype none

module led_pixel_color_pipeline
  import lpcp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_strobe,
  output out_item_t      out_item,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [CHAN_W-1:0] cfg_data
);

  // Never back-pressure: every stage advances on every clock
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Global brightness register
  logic [CHAN_W-1:0] gbright_r, gbright_nxt;

  always_comb begin
    gbright_nxt = gbright_r;
    if (cfg_valid && cfg_ready) begin
      gbright_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gbright_r <= CHAN_MAX;
    end else begin
      gbright_r <= gbright_nxt;
    end
  end

  // Colour conversion front end
  logic      acc_vld;
  logic      rgb_vld;
  rgb_item_t rgb_item;

  assign acc_vld = start && !busy;

  lpcp_hsv u_hsv (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (acc_vld),
    .in_item  (in_item),
    .out_vld  (rgb_vld),
    .out_item (rgb_item)
  );

  // One scaler per channel, all in lockstep
  logic [CHAN_W-1:0] red_lvl, green_lvl, blue_lvl;

  lpcp_shade u_shade_red (
    .clk          (clk),
    .chan         (rgb_item.red),
    .seg_level    (rgb_item.seg_level),
    .global_level (gbright_r),
    .level_out    (red_lvl)
  );

  lpcp_shade u_shade_green (
    .clk          (clk),
    .chan         (rgb_item.green),
    .seg_level    (rgb_item.seg_level),
    .global_level (gbright_r),
    .level_out    (green_lvl)
  );

  lpcp_shade u_shade_blue (
    .clk          (clk),
    .chan         (rgb_item.blue),
    .seg_level    (rgb_item.seg_level),
    .global_level (gbright_r),
    .level_out    (blue_lvl)
  );

  // Carry valid and index alongside the scalers
  logic [SHADE_LAT-1:0] vld_r;
  logic [INDEX_W-1:0]   idx_r [SHADE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SHADE_LAT-2:0], rgb_vld};
    end
    idx_r[0] <= rgb_item.led_index;
    for (int i = 1; i < SHADE_LAT; i++) begin
      idx_r[i] <= idx_r[i-1];
    end
  end

  assign out_strobe         = vld_r[SHADE_LAT-1];
  assign out_item.out_index = idx_r[SHADE_LAT-1];
  assign out_item.red_out   = red_lvl;
  assign out_item.green_out = green_lvl;
  assign out_item.blue_out  = blue_lvl;

  // Every result strobe traces back to a start pulse at the input
  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, 9))
    else $error("result strobe without a matching transaction");

  // A converted pixel always leaves the scalers as a result strobe
  a_front_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    rgb_vld |-> ##5 out_strobe)
    else $error("pixel lost between converter and output");

  // A configuration write lands in the brightness register
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (gbright_r == $past(cfg_data)))
    else $error("global brightness write not taken");

endmodule

`default_nettype wire
